>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the moving average core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, held off during reset.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, held off during reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

>>> rtl/core/dtsma_pkg.sv
// ----------------------------------------------------------------------------
// dtsma_pkg
// Shared widths, types and default sizes of the moving average core.
// ----------------------------------------------------------------------------
package dtsma_pkg;

  // Field and accumulator widths
  localparam int SAMPLE_W = 8;
  localparam int SUM_W    = 14;

  // Default sizes
  localparam int WINDOW_LEN_DEF  = 8;
  localparam int HISTORY_LEN_DEF = 4;
  localparam int DECIMATION_DEF  = 4;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [SUM_W-1:0]    sum_t;

  // Per-stage control traveling with each word through the pipeline
  typedef struct packed {
    logic    valid;
    logic    push;
    sample_t sample;
  } stage_t;

endpackage

>>> rtl/core/decimated_two_stage_moving_average_core.sv
// ----------------------------------------------------------------------------
// decimated_two_stage_moving_average_core
// Window average of drive samples, decimated into a history average.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one signed 8-bit sample per word.
//   out_* : one result word per input word, in order. tdata carries the
//           latest sample and the mean of the average history, tuser flags
//           words on which a new window average entered the history.
//   Every DECIMATION-th word, starting with the first after reset, the
//   window average (new sample included) is pushed into the history.
//   Throughput is one word per cycle while the receiver does not stall,
//   set by the running-sum update of each delay line and one
//   constant-reciprocal multiply per divide stage.
//   Stages: window update, window divide, history update, history divide
//   into the output register.
//   Reset (rst_n low, synchronous) clears both delay lines, the sums and
//   the decimation counter; zeros count in the averages until replaced.
//   When the receiver stalls with the output register full, the whole
//   pipeline holds and in_tready drops; otherwise it keeps moving.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module decimated_two_stage_moving_average_core #(
  parameter int WINDOW_LEN  = dtsma_pkg::WINDOW_LEN_DEF,
  parameter int HISTORY_LEN = dtsma_pkg::HISTORY_LEN_DEF,
  parameter int DECIMATION  = dtsma_pkg::DECIMATION_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] sample
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] latest_sample, [15:8] history_mean
  output logic        out_tuser   // [0] history_updated
);

  import dtsma_pkg::*;

  localparam int CntW = (DECIMATION > 1) ? $clog2(DECIMATION) : 1;

  logic    adv;
  logic    in_acc;
  sample_t s_in;
  logic    push_in;

  logic [CntW-1:0] cnt_r, cnt_nxt;
  sum_t    win_sum_r, win_sum_nxt;
  sum_t    hist_sum_r, hist_sum_nxt;
  logic    hist_en;

  stage_t  st1_r, st2_r, st3_r, st4_r;
  stage_t  st1_nxt;
  sample_t avg2_r, avg_c, mean_c, mean_r;

  sample_t win_q  [WINDOW_LEN];
  sample_t hist_q [HISTORY_LEN];

  // Global advance: the pipeline moves unless the output word is stuck
  assign adv       = !st4_r.valid || out_tready;
  assign in_tready = adv;
  assign in_acc    = in_tvalid && adv;
  assign s_in      = sample_t'(in_tdata);
  assign push_in   = (cnt_r == '0);

  // Decimation counter, wraps at DECIMATION
  always_comb begin
    if (cnt_r == CntW'(DECIMATION - 1)) begin
      cnt_nxt = '0;
    end else begin
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  // Window delay line: newest enters the top cell, oldest leaves cell 0
  for (genvar i = 0; i < WINDOW_LEN; i++) begin : g_win
    if (i == WINDOW_LEN - 1) begin : g_top
      dtsma_cell #(.DataW(SAMPLE_W)) u_cell (
        .clk(clk), .rst_n(rst_n), .en(in_acc), .d(s_in), .q(win_q[i])
      );
    end else begin : g_mid
      dtsma_cell #(.DataW(SAMPLE_W)) u_cell (
        .clk(clk), .rst_n(rst_n), .en(in_acc), .d(win_q[i+1]), .q(win_q[i])
      );
    end
  end

  assign win_sum_nxt = win_sum_r - sum_t'(win_q[0]) + sum_t'(s_in);

  // Stage 1 word
  always_comb begin
    st1_nxt.valid  = in_acc;
    st1_nxt.push   = push_in;
    st1_nxt.sample = s_in;
  end

  // Window average from the running sum
  dtsma_cdiv #(.DIVISOR(WINDOW_LEN)) u_win_div (
    .num(win_sum_r),
    .quo(avg_c)
  );

  // History delay line, shifted only on a pushing word
  assign hist_en = adv && st2_r.valid && st2_r.push;

  for (genvar j = 0; j < HISTORY_LEN; j++) begin : g_hist
    if (j == HISTORY_LEN - 1) begin : g_top
      dtsma_cell #(.DataW(SAMPLE_W)) u_cell (
        .clk(clk), .rst_n(rst_n), .en(hist_en), .d(avg2_r), .q(hist_q[j])
      );
    end else begin : g_mid
      dtsma_cell #(.DataW(SAMPLE_W)) u_cell (
        .clk(clk), .rst_n(rst_n), .en(hist_en), .d(hist_q[j+1]), .q(hist_q[j])
      );
    end
  end

  assign hist_sum_nxt = hist_sum_r - sum_t'(hist_q[0]) + sum_t'(avg2_r);

  // History mean from the running sum
  dtsma_cdiv #(.DIVISOR(HISTORY_LEN)) u_hist_div (
    .num(hist_sum_r),
    .quo(mean_c)
  );

  // Control state, running sums and stage registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      win_sum_r  <= '0;
      hist_sum_r <= '0;
      st1_r      <= '0;
      st2_r      <= '0;
      st3_r      <= '0;
      st4_r      <= '0;
      avg2_r     <= '0;
      mean_r     <= '0;
    end else begin
      if (in_acc) begin
        cnt_r     <= cnt_nxt;
        win_sum_r <= win_sum_nxt;
      end
      if (hist_en) begin
        hist_sum_r <= hist_sum_nxt;
      end
      if (adv) begin
        st1_r  <= st1_nxt;
        st2_r  <= st1_r;
        st3_r  <= st2_r;
        st4_r  <= st3_r;
        avg2_r <= avg_c;
        mean_r <= mean_c;
      end
    end
  end

  assign out_tvalid = st4_r.valid;
  assign out_tdata  = {mean_r, st4_r.sample};
  assign out_tuser  = st4_r.push;

  // Checks
  `ASSERT_IMPL(a_cnt_range, clk, rst_n, 1'b1, cnt_r <= CntW'(DECIMATION - 1))
  `ASSERT_NEXT(a_win_hold, clk, rst_n, !in_acc, $stable(win_sum_r))
  `ASSERT_NEXT(a_hist_hold, clk, rst_n, !hist_en, $stable(hist_sum_r))
  `ASSERT_NEXT(a_acc_to_st1, clk, rst_n, in_acc, st1_r.valid)
  `ASSERT_NEXT(a_stall_hold, clk, rst_n, !adv, $stable(mean_r) && $stable(st4_r))

endmodule

>>> rtl/core/dtsma_cell.sv
// ----------------------------------------------------------------------------
// dtsma_cell
// One tap of a delay line: loads the value on d (its neighbor's, or the new entry at the top) when enabled.
// ----------------------------------------------------------------------------
module dtsma_cell #(
  parameter int DataW = dtsma_pkg::SAMPLE_W
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic [DataW-1:0] d,
  output logic [DataW-1:0] q
);

  logic [DataW-1:0] q_r;

  // Tap register, cleared at reset so start-up zeros count in the sums
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= '0;
    end else if (en) begin
      q_r <= d;
    end
  end

  assign q = q_r;

endmodule

>>> rtl/core/dtsma_cdiv.sv
// ----------------------------------------------------------------------------
// dtsma_cdiv
// Signed divide by a build-time constant, truncating toward zero.
// ----------------------------------------------------------------------------
module dtsma_cdiv #(
  parameter int DIVISOR = dtsma_pkg::WINDOW_LEN_DEF
) (
  input  dtsma_pkg::sum_t    num,
  output dtsma_pkg::sample_t quo
);

  import dtsma_pkg::*;

  // Reciprocal m = ceil(2^K / d) with K = N + ceil(log2 d) is exact for
  // every magnitude below 2^N, so no correction step is needed.
  localparam int Shift = SUM_W + $clog2(DIVISOR);
  localparam longint unsigned Mult =
    ((longint'(1) << Shift) + longint'(DIVISOR) - 1) / longint'(DIVISOR);
  localparam int MultW = Shift + 1;
  localparam int ProdW = SUM_W + MultW;

  logic             neg;
  logic [SUM_W-1:0] mag;
  logic [MultW-1:0] recip;
  logic [ProdW-1:0] prod;
  logic [SAMPLE_W-1:0] qmag;

  // Magnitude, scaled multiply, sign restore
  always_comb begin
    neg   = num[SUM_W-1];
    mag   = neg ? (SUM_W)'(-num) : (SUM_W)'(num);
    recip = MultW'(Mult);
    prod  = ProdW'(mag) * ProdW'(recip);
    qmag  = prod[Shift +: SAMPLE_W];
    quo   = neg ? sample_t'(-qmag) : sample_t'(qmag);
  end

endmodule
